// ===== src/wide_line_quad_setup_defines.svh =====
// Assertion macros shared by the wide line quad setup checker.
`ifndef WIDE_LINE_QUAD_SETUP_DEFINES_SVH
`define WIDE_LINE_QUAD_SETUP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define WLQS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define WLQS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/wlqs_pkg.sv =====
// Shared types and constants for the wide line quad setup pipeline.
package wlqs_pkg;

    localparam int unsigned HALF_WIDTH_RESET = 15;

    // Per-word control that travels down the pipeline next to the data.
    typedef struct packed {
        logic valid;
        logic degen;
        logic w_neg;
        logic h_neg;
    } seg_flags_t;

endpackage

// ===== src/wlqs_prep.sv =====
// Front end: deltas, magnitudes, squares and the two search targets.
module wlqs_prep #(
    parameter int COORD_BITS  = 16,
    parameter int OFFSET_BITS = 8
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      run,
    input  logic                                      in_valid,
    input  logic signed [COORD_BITS-1:0]              sx_in,
    input  logic signed [COORD_BITS-1:0]              sy_in,
    input  logic signed [COORD_BITS-1:0]              ex_in,
    input  logic signed [COORD_BITS-1:0]              ey_in,
    input  logic        [OFFSET_BITS-1:0]             r_in,
    output wlqs_pkg::seg_flags_t                      flags_out,
    output logic signed [COORD_BITS-1:0]              sx_out,
    output logic signed [COORD_BITS-1:0]              sy_out,
    output logic signed [COORD_BITS-1:0]              ex_out,
    output logic signed [COORD_BITS-1:0]              ey_out,
    output logic        [OFFSET_BITS-1:0]             r_out,
    output logic        [2*COORD_BITS+2:0]            sum_out,
    output logic        [2*OFFSET_BITS+2*COORD_BITS+1:0] tgtx_out,
    output logic        [2*OFFSET_BITS+2*COORD_BITS+1:0] tgty_out
);

    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int MAG_BITS  = COORD_BITS + 1;
    localparam int MSQ_BITS  = 2 * MAG_BITS;
    localparam int SUM_BITS  = 2 * MAG_BITS + 1;
    localparam int RSQ_BITS  = 2 * OFFSET_BITS;
    localparam int TGT_BITS  = 2 * OFFSET_BITS + 2 * MAG_BITS;

    // stage 1: endpoint deltas
    logic                          v1_reg;
    logic signed [COORD_BITS-1:0]  sx1_reg, sy1_reg, ex1_reg, ey1_reg;
    logic        [OFFSET_BITS-1:0] r1_reg;
    logic signed [DIFF_BITS-1:0]   w1_reg, h1_reg;
    logic signed [DIFF_BITS-1:0]   w_next, h_next;

    // stage 2: magnitudes and flags
    wlqs_pkg::seg_flags_t          f2_reg, f2_next;
    logic signed [COORD_BITS-1:0]  sx2_reg, sy2_reg, ex2_reg, ey2_reg;
    logic        [OFFSET_BITS-1:0] r2_reg;
    logic        [MAG_BITS-1:0]    aw2_reg, ah2_reg, aw_next, ah_next;

    // stage 3: squares
    wlqs_pkg::seg_flags_t          f3_reg;
    logic signed [COORD_BITS-1:0]  sx3_reg, sy3_reg, ex3_reg, ey3_reg;
    logic        [OFFSET_BITS-1:0] r3_reg;
    logic        [MSQ_BITS-1:0]    awsq3_reg, ahsq3_reg;
    logic        [RSQ_BITS-1:0]    rsq3_reg;

    // stage 4: sum of squares and targets
    wlqs_pkg::seg_flags_t          f4_reg;
    logic signed [COORD_BITS-1:0]  sx4_reg, sy4_reg, ex4_reg, ey4_reg;
    logic        [OFFSET_BITS-1:0] r4_reg;
    logic        [SUM_BITS-1:0]    sum4_reg;
    logic        [TGT_BITS-1:0]    tgtx4_reg, tgty4_reg;

    always_comb
    begin
        w_next = DIFF_BITS'(ex_in) - DIFF_BITS'(sx_in);
        h_next = DIFF_BITS'(ey_in) - DIFF_BITS'(sy_in);
        aw_next = w1_reg[DIFF_BITS-1] ? MAG_BITS'(~w1_reg + 1'b1) : MAG_BITS'(w1_reg);
        ah_next = h1_reg[DIFF_BITS-1] ? MAG_BITS'(~h1_reg + 1'b1) : MAG_BITS'(h1_reg);
        f2_next.valid = v1_reg;
        f2_next.degen = (w1_reg == '0) && (h1_reg == '0);
        f2_next.w_neg = w1_reg[DIFF_BITS-1];
        f2_next.h_neg = h1_reg[DIFF_BITS-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            f2_reg <= '0;
            f3_reg <= '0;
            f4_reg <= '0;
        end
        else if (run)
        begin
            v1_reg <= in_valid;
            f2_reg <= f2_next;
            f3_reg <= f2_reg;
            f4_reg <= f3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (run)
        begin
            sx1_reg <= sx_in;
            sy1_reg <= sy_in;
            ex1_reg <= ex_in;
            ey1_reg <= ey_in;
            r1_reg  <= r_in;
            w1_reg  <= w_next;
            h1_reg  <= h_next;

            sx2_reg <= sx1_reg;
            sy2_reg <= sy1_reg;
            ex2_reg <= ex1_reg;
            ey2_reg <= ey1_reg;
            r2_reg  <= r1_reg;
            aw2_reg <= aw_next;
            ah2_reg <= ah_next;

            sx3_reg   <= sx2_reg;
            sy3_reg   <= sy2_reg;
            ex3_reg   <= ex2_reg;
            ey3_reg   <= ey2_reg;
            r3_reg    <= r2_reg;
            awsq3_reg <= MSQ_BITS'(aw2_reg) * MSQ_BITS'(aw2_reg);
            ahsq3_reg <= MSQ_BITS'(ah2_reg) * MSQ_BITS'(ah2_reg);
            rsq3_reg  <= RSQ_BITS'(r2_reg) * RSQ_BITS'(r2_reg);

            sx4_reg   <= sx3_reg;
            sy4_reg   <= sy3_reg;
            ex4_reg   <= ex3_reg;
            ey4_reg   <= ey3_reg;
            r4_reg    <= r3_reg;
            sum4_reg  <= SUM_BITS'(awsq3_reg) + SUM_BITS'(ahsq3_reg);
            tgtx4_reg <= TGT_BITS'(rsq3_reg) * TGT_BITS'(ahsq3_reg);
            tgty4_reg <= TGT_BITS'(rsq3_reg) * TGT_BITS'(awsq3_reg);
        end
    end

    assign flags_out = f4_reg;
    assign sx_out    = sx4_reg;
    assign sy_out    = sy4_reg;
    assign ex_out    = ex4_reg;
    assign ey_out    = ey4_reg;
    assign r_out     = r4_reg;
    assign sum_out   = sum4_reg;
    assign tgtx_out  = tgtx4_reg;
    assign tgty_out  = tgty4_reg;

endmodule

// ===== src/wlqs_search_bit.sv =====
// One bit of the offset search: multiply stage, then compare-and-keep stage.
module wlqs_search_bit #(
    parameter int COORD_BITS  = 16,
    parameter int OFFSET_BITS = 8,
    parameter int BIT         = 0
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      run,
    input  wlqs_pkg::seg_flags_t                      flags_in,
    input  logic signed [COORD_BITS-1:0]              sx_in,
    input  logic signed [COORD_BITS-1:0]              sy_in,
    input  logic signed [COORD_BITS-1:0]              ex_in,
    input  logic signed [COORD_BITS-1:0]              ey_in,
    input  logic        [OFFSET_BITS-1:0]             r_in,
    input  logic        [2*COORD_BITS+2:0]            sum_in,
    input  logic        [2*OFFSET_BITS+2*COORD_BITS+1:0] tgtx_in,
    input  logic        [2*OFFSET_BITS+2*COORD_BITS+1:0] tgty_in,
    input  logic        [OFFSET_BITS-1:0]             qx_in,
    input  logic        [OFFSET_BITS-1:0]             qy_in,
    input  logic        [2*OFFSET_BITS-1:0]           qsqx_in,
    input  logic        [2*OFFSET_BITS-1:0]           qsqy_in,
    output wlqs_pkg::seg_flags_t                      flags_out,
    output logic signed [COORD_BITS-1:0]              sx_out,
    output logic signed [COORD_BITS-1:0]              sy_out,
    output logic signed [COORD_BITS-1:0]              ex_out,
    output logic signed [COORD_BITS-1:0]              ey_out,
    output logic        [OFFSET_BITS-1:0]             r_out,
    output logic        [2*COORD_BITS+2:0]            sum_out,
    output logic        [2*OFFSET_BITS+2*COORD_BITS+1:0] tgtx_out,
    output logic        [2*OFFSET_BITS+2*COORD_BITS+1:0] tgty_out,
    output logic        [OFFSET_BITS-1:0]             qx_out,
    output logic        [OFFSET_BITS-1:0]             qy_out,
    output logic        [2*OFFSET_BITS-1:0]           qsqx_out,
    output logic        [2*OFFSET_BITS-1:0]           qsqy_out
);

    localparam int SQ_BITS   = 2 * OFFSET_BITS;
    localparam int SUM_BITS  = 2 * COORD_BITS + 3;
    localparam int TGT_BITS  = 2 * OFFSET_BITS + 2 * COORD_BITS + 2;
    localparam int PROD_BITS = SQ_BITS + SUM_BITS;

    localparam logic [OFFSET_BITS-1:0] BIT_MASK = OFFSET_BITS'(1) << BIT;
    localparam logic [SQ_BITS-1:0]     BIT_SQ   = SQ_BITS'(1) << (2 * BIT);

    // stage A: candidate, its square, and candidate^2 * S
    wlqs_pkg::seg_flags_t          fa_reg;
    logic signed [COORD_BITS-1:0]  sxa_reg, sya_reg, exa_reg, eya_reg;
    logic        [OFFSET_BITS-1:0] ra_reg;
    logic        [SUM_BITS-1:0]    suma_reg;
    logic        [TGT_BITS-1:0]    tgtxa_reg, tgtya_reg;
    logic        [OFFSET_BITS-1:0] qxa_reg, qya_reg, candxa_reg, candya_reg;
    logic        [SQ_BITS-1:0]     qsqxa_reg, qsqya_reg, csqxa_reg, csqya_reg;
    logic        [PROD_BITS-1:0]   prodxa_reg, prodya_reg;
    logic                          okxa_reg, okya_reg;
    logic        [OFFSET_BITS-1:0] candx_next, candy_next;
    logic        [SQ_BITS-1:0]     csqx_next, csqy_next;

    // stage B: decision
    wlqs_pkg::seg_flags_t          fb_reg;
    logic signed [COORD_BITS-1:0]  sxb_reg, syb_reg, exb_reg, eyb_reg;
    logic        [OFFSET_BITS-1:0] rb_reg;
    logic        [SUM_BITS-1:0]    sumb_reg;
    logic        [TGT_BITS-1:0]    tgtxb_reg, tgtyb_reg;
    logic        [OFFSET_BITS-1:0] qxb_reg, qyb_reg;
    logic        [SQ_BITS-1:0]     qsqxb_reg, qsqyb_reg;
    logic                          takex, takey;

    // q has no bits at or below BIT, so (q + 2^b)^2 = q^2 + q*2^(b+1) + 2^(2b)
    always_comb
    begin
        candx_next = qx_in | BIT_MASK;
        candy_next = qy_in | BIT_MASK;
        csqx_next  = qsqx_in + (SQ_BITS'(qx_in) << (BIT + 1)) + BIT_SQ;
        csqy_next  = qsqy_in + (SQ_BITS'(qy_in) << (BIT + 1)) + BIT_SQ;
        takex = okxa_reg && (prodxa_reg <= PROD_BITS'(tgtxa_reg));
        takey = okya_reg && (prodya_reg <= PROD_BITS'(tgtya_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fa_reg <= '0;
            fb_reg <= '0;
        end
        else if (run)
        begin
            fa_reg <= flags_in;
            fb_reg <= fa_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (run)
        begin
            sxa_reg    <= sx_in;
            sya_reg    <= sy_in;
            exa_reg    <= ex_in;
            eya_reg    <= ey_in;
            ra_reg     <= r_in;
            suma_reg   <= sum_in;
            tgtxa_reg  <= tgtx_in;
            tgtya_reg  <= tgty_in;
            qxa_reg    <= qx_in;
            qya_reg    <= qy_in;
            qsqxa_reg  <= qsqx_in;
            qsqya_reg  <= qsqy_in;
            candxa_reg <= candx_next;
            candya_reg <= candy_next;
            csqxa_reg  <= csqx_next;
            csqya_reg  <= csqy_next;
            prodxa_reg <= PROD_BITS'(csqx_next) * PROD_BITS'(sum_in);
            prodya_reg <= PROD_BITS'(csqy_next) * PROD_BITS'(sum_in);
            okxa_reg   <= candx_next <= r_in;
            okya_reg   <= candy_next <= r_in;

            sxb_reg   <= sxa_reg;
            syb_reg   <= sya_reg;
            exb_reg   <= exa_reg;
            eyb_reg   <= eya_reg;
            rb_reg    <= ra_reg;
            sumb_reg  <= suma_reg;
            tgtxb_reg <= tgtxa_reg;
            tgtyb_reg <= tgtya_reg;
            qxb_reg   <= takex ? candxa_reg : qxa_reg;
            qyb_reg   <= takey ? candya_reg : qya_reg;
            qsqxb_reg <= takex ? csqxa_reg : qsqxa_reg;
            qsqyb_reg <= takey ? csqya_reg : qsqya_reg;
        end
    end

    assign flags_out = fb_reg;
    assign sx_out    = sxb_reg;
    assign sy_out    = syb_reg;
    assign ex_out    = exb_reg;
    assign ey_out    = eyb_reg;
    assign r_out     = rb_reg;
    assign sum_out   = sumb_reg;
    assign tgtx_out  = tgtxb_reg;
    assign tgty_out  = tgtyb_reg;
    assign qx_out    = qxb_reg;
    assign qy_out    = qyb_reg;
    assign qsqx_out  = qsqxb_reg;
    assign qsqy_out  = qsqyb_reg;

endmodule

// ===== src/wlqs_corner.sv =====
// Back end: signed offsets, the eight corner sums, output register and skid word.
module wlqs_corner #(
    parameter int COORD_BITS  = 16,
    parameter int OFFSET_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  wlqs_pkg::seg_flags_t          flags_in,
    input  logic signed [COORD_BITS-1:0]  sx_in,
    input  logic signed [COORD_BITS-1:0]  sy_in,
    input  logic signed [COORD_BITS-1:0]  ex_in,
    input  logic signed [COORD_BITS-1:0]  ey_in,
    input  logic        [OFFSET_BITS-1:0] r_in,
    input  logic        [OFFSET_BITS-1:0] qx_in,
    input  logic        [OFFSET_BITS-1:0] qy_in,
    input  logic                          out_stall,
    output logic                          run,
    output logic                          out_valid,
    output logic signed [COORD_BITS:0]    corner0_x,
    output logic signed [COORD_BITS:0]    corner0_y,
    output logic signed [COORD_BITS:0]    corner1_x,
    output logic signed [COORD_BITS:0]    corner1_y,
    output logic signed [COORD_BITS:0]    corner2_x,
    output logic signed [COORD_BITS:0]    corner2_y,
    output logic signed [COORD_BITS:0]    corner3_x,
    output logic signed [COORD_BITS:0]    corner3_y
);

    localparam int OUT_BITS = COORD_BITS + 1;
    localparam int EXT_BITS = ((COORD_BITS > OFFSET_BITS) ? COORD_BITS : OFFSET_BITS) + 2;

    logic signed [EXT_BITS-1:0] dx, dy;
    logic signed [EXT_BITS-1:0] sx_e, sy_e, ex_e, ey_e;
    logic        [OFFSET_BITS-1:0] mx, my;
    logic signed [OUT_BITS-1:0] corner_next [8];
    logic signed [OUT_BITS-1:0] out_reg     [8];
    logic signed [OUT_BITS-1:0] skid_reg    [8];
    logic out_valid_reg, skid_valid_reg;
    logic push, out_take;

    always_comb
    begin
        mx = flags_in.degen ? '0 : qx_in;
        my = flags_in.degen ? r_in : qy_in;
        // dx points against the slope: negative when w and h share a sign
        dx = (flags_in.w_neg == flags_in.h_neg) ? -EXT_BITS'(mx) : EXT_BITS'(mx);
        dy = EXT_BITS'(my);
        sx_e = EXT_BITS'(sx_in);
        sy_e = EXT_BITS'(sy_in);
        ex_e = EXT_BITS'(ex_in);
        ey_e = EXT_BITS'(ey_in);
        corner_next[0] = OUT_BITS'(sx_e + dx);
        corner_next[1] = OUT_BITS'(sy_e + dy);
        corner_next[2] = OUT_BITS'(sx_e - dx);
        corner_next[3] = OUT_BITS'(sy_e - dy);
        corner_next[4] = OUT_BITS'(ex_e - dx);
        corner_next[5] = OUT_BITS'(ey_e - dy);
        corner_next[6] = OUT_BITS'(ex_e + dx);
        corner_next[7] = OUT_BITS'(ey_e + dy);
    end

    // pipeline moves whenever the skid word is free
    assign run      = !skid_valid_reg;
    assign push     = run && flags_in.valid;
    assign out_take = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_reg <= corner_next;
            end
            else
            begin
                out_reg <= corner_next;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign corner0_x = out_reg[0];
    assign corner0_y = out_reg[1];
    assign corner1_x = out_reg[2];
    assign corner1_y = out_reg[3];
    assign corner2_x = out_reg[4];
    assign corner2_y = out_reg[5];
    assign corner3_x = out_reg[6];
    assign corner3_y = out_reg[7];

endmodule

// ===== src/wide_line_quad_setup.sv =====
// Top level of the wide line quad setup pipeline.
// Throughput: one segment per cycle while in_stall is low; each offset bit costs a multiply stage and a compare stage.
// in_stall rises only while the output register and its one skid word both hold results.
// Reset clears every valid bit and sets half_width to 15; data registers are not reset.
module wide_line_quad_setup #(
    parameter int COORD_BITS  = 16,
    parameter int OFFSET_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_BITS-1:0]  start_x,
    input  logic signed [COORD_BITS-1:0]  start_y,
    input  logic signed [COORD_BITS-1:0]  end_x,
    input  logic signed [COORD_BITS-1:0]  end_y,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [COORD_BITS:0]    corner0_x,
    output logic signed [COORD_BITS:0]    corner0_y,
    output logic signed [COORD_BITS:0]    corner1_x,
    output logic signed [COORD_BITS:0]    corner1_y,
    output logic signed [COORD_BITS:0]    corner2_x,
    output logic signed [COORD_BITS:0]    corner2_y,
    output logic signed [COORD_BITS:0]    corner3_x,
    output logic signed [COORD_BITS:0]    corner3_y,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic        [OFFSET_BITS-1:0] half_width
);

    localparam int SUM_BITS = 2 * COORD_BITS + 3;
    localparam int TGT_BITS = 2 * OFFSET_BITS + 2 * COORD_BITS + 2;
    localparam int SQ_BITS  = 2 * OFFSET_BITS;

    logic                   run;
    logic [OFFSET_BITS-1:0] half_width_reg;

    wlqs_pkg::seg_flags_t          flags_s [0:OFFSET_BITS];
    logic signed [COORD_BITS-1:0]  sx_s    [0:OFFSET_BITS];
    logic signed [COORD_BITS-1:0]  sy_s    [0:OFFSET_BITS];
    logic signed [COORD_BITS-1:0]  ex_s    [0:OFFSET_BITS];
    logic signed [COORD_BITS-1:0]  ey_s    [0:OFFSET_BITS];
    logic        [OFFSET_BITS-1:0] r_s     [0:OFFSET_BITS];
    logic        [OFFSET_BITS-1:0] qx_s    [0:OFFSET_BITS];
    logic        [OFFSET_BITS-1:0] qy_s    [0:OFFSET_BITS];
    logic        [SUM_BITS-1:0]    sum_s   [0:OFFSET_BITS];
    logic        [TGT_BITS-1:0]    tgtx_s  [0:OFFSET_BITS];
    logic        [TGT_BITS-1:0]    tgty_s  [0:OFFSET_BITS];
    logic        [SQ_BITS-1:0]     qsqx_s  [0:OFFSET_BITS];
    logic        [SQ_BITS-1:0]     qsqy_s  [0:OFFSET_BITS];

    assign cfg_ready = 1'b1;
    assign in_stall  = !run;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_width_reg <= OFFSET_BITS'(wlqs_pkg::HALF_WIDTH_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            half_width_reg <= half_width;
        end
    end

    wlqs_prep #(
        .COORD_BITS (COORD_BITS),
        .OFFSET_BITS(OFFSET_BITS)
    ) u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .run      (run),
        .in_valid (in_valid),
        .sx_in    (start_x),
        .sy_in    (start_y),
        .ex_in    (end_x),
        .ey_in    (end_y),
        .r_in     (half_width_reg),
        .flags_out(flags_s[0]),
        .sx_out   (sx_s[0]),
        .sy_out   (sy_s[0]),
        .ex_out   (ex_s[0]),
        .ey_out   (ey_s[0]),
        .r_out    (r_s[0]),
        .sum_out  (sum_s[0]),
        .tgtx_out (tgtx_s[0]),
        .tgty_out (tgty_s[0])
    );

    assign qx_s[0]   = '0;
    assign qy_s[0]   = '0;
    assign qsqx_s[0] = '0;
    assign qsqy_s[0] = '0;

    // one search slice per offset bit, top bit first
    for (genvar i = 0; i < OFFSET_BITS; i++)
    begin : g_search
        wlqs_search_bit #(
            .COORD_BITS (COORD_BITS),
            .OFFSET_BITS(OFFSET_BITS),
            .BIT        (OFFSET_BITS - 1 - i)
        ) u_bit (
            .clk      (clk),
            .rst_n    (rst_n),
            .run      (run),
            .flags_in (flags_s[i]),
            .sx_in    (sx_s[i]),
            .sy_in    (sy_s[i]),
            .ex_in    (ex_s[i]),
            .ey_in    (ey_s[i]),
            .r_in     (r_s[i]),
            .sum_in   (sum_s[i]),
            .tgtx_in  (tgtx_s[i]),
            .tgty_in  (tgty_s[i]),
            .qx_in    (qx_s[i]),
            .qy_in    (qy_s[i]),
            .qsqx_in  (qsqx_s[i]),
            .qsqy_in  (qsqy_s[i]),
            .flags_out(flags_s[i+1]),
            .sx_out   (sx_s[i+1]),
            .sy_out   (sy_s[i+1]),
            .ex_out   (ex_s[i+1]),
            .ey_out   (ey_s[i+1]),
            .r_out    (r_s[i+1]),
            .sum_out  (sum_s[i+1]),
            .tgtx_out (tgtx_s[i+1]),
            .tgty_out (tgty_s[i+1]),
            .qx_out   (qx_s[i+1]),
            .qy_out   (qy_s[i+1]),
            .qsqx_out (qsqx_s[i+1]),
            .qsqy_out (qsqy_s[i+1])
        );
    end

    wlqs_corner #(
        .COORD_BITS (COORD_BITS),
        .OFFSET_BITS(OFFSET_BITS)
    ) u_corner (
        .clk      (clk),
        .rst_n    (rst_n),
        .flags_in (flags_s[OFFSET_BITS]),
        .sx_in    (sx_s[OFFSET_BITS]),
        .sy_in    (sy_s[OFFSET_BITS]),
        .ex_in    (ex_s[OFFSET_BITS]),
        .ey_in    (ey_s[OFFSET_BITS]),
        .r_in     (r_s[OFFSET_BITS]),
        .qx_in    (qx_s[OFFSET_BITS]),
        .qy_in    (qy_s[OFFSET_BITS]),
        .out_stall(out_stall),
        .run      (run),
        .out_valid(out_valid),
        .corner0_x(corner0_x),
        .corner0_y(corner0_y),
        .corner1_x(corner1_x),
        .corner1_y(corner1_y),
        .corner2_x(corner2_x),
        .corner2_y(corner2_y),
        .corner3_x(corner3_x),
        .corner3_y(corner3_y)
    );

endmodule

// ===== src/wlqs_checker.sv =====
// Port-level checker for the wide line quad setup block, with its bind.
`include "wide_line_quad_setup_defines.svh"

module wlqs_checker #(
    parameter int COORD_BITS = 16
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_stall,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic signed [COORD_BITS:0] corner0_x,
    input logic signed [COORD_BITS:0] corner0_y,
    input logic signed [COORD_BITS:0] corner1_x,
    input logic signed [COORD_BITS:0] corner1_y,
    input logic signed [COORD_BITS:0] corner2_x,
    input logic signed [COORD_BITS:0] corner2_y,
    input logic signed [COORD_BITS:0] corner3_x,
    input logic signed [COORD_BITS:0] corner3_y
);

    logic                          out_held;
    logic [8*(COORD_BITS+1)-1:0]   corners;

    assign out_held = out_valid && out_stall;
    assign corners  = {corner3_y, corner3_x, corner2_y, corner2_x,
                       corner1_y, corner1_x, corner0_y, corner0_x};

    `WLQS_ASSERT_NEXT(a_out_hold, out_held, out_valid, "result word dropped under stall")
    `WLQS_ASSERT_NEXT(a_out_stable, out_held, $stable(corners), "result word changed under stall")
    // input side only backs up once a word is waiting at the output
    `WLQS_ASSERT_SAME(a_stall_has_word, in_stall, out_valid, "in_stall with no result waiting")
    `WLQS_ASSERT_SAME(a_stall_cause, $rose(in_stall), $past(out_held), "in_stall rose unprompted")

endmodule

bind wide_line_quad_setup wlqs_checker #(
    .COORD_BITS(COORD_BITS)
) u_wlqs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .corner0_x(corner0_x),
    .corner0_y(corner0_y),
    .corner1_x(corner1_x),
    .corner1_y(corner1_y),
    .corner2_x(corner2_x),
    .corner2_y(corner2_y),
    .corner3_x(corner3_x),
    .corner3_y(corner3_y)
);
